// ===== sv/bias_scaled_soft_histogram_defines.svh =====
// Assertion macros shared by the histogram RTL.
`ifndef BIAS_SCALED_SOFT_HISTOGRAM_DEFINES_SVH
`define BIAS_SCALED_SOFT_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BSH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bsh_pkg.sv =====
// Package for the soft histogram: sequencer states, codes and the exp2 table.
package bsh_pkg;

	// Item kinds carried in tuser
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Register indexes
	localparam logic [7:0] REG_BIN_SCALE = 8'd0;
	localparam logic [7:0] REG_NUM_BINS  = 8'd1;

	localparam logic [31:0] BIN_SCALE_RST = 32'd65536;
	localparam logic [10:0] NUM_BINS_RST  = 11'd1024;

	// log2(e) in Q16
	localparam logic [31:0] LOG2E_Q16 = 32'd94548;
	// (x+32768)*LOG2E + U_OFS == x*LOG2E + 16<<28
	localparam logic [32:0] U_OFS = 33'd1196818432;

	localparam logic [47:0] ONE_Q16 = 48'd65536;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_U,
		ST_Y0,
		ST_DM,
		ST_M,
		ST_PL,
		ST_PH,
		ST_PS,
		ST_SH,
		ST_W0,
		ST_W1,
		ST_RA,
		ST_H,
		ST_HH,
		ST_DC,
		ST_DIV,
		ST_OUT
	} st_t;

	typedef logic [31:0] pow2_tab_t [17];

	// Integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bitv;
		v    = val;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bitv > v) bitv = bitv >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bitv != 0) begin
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// 2^(i/16) in Q30 from repeated roots of two
	function automatic pow2_tab_t build_pow2();
		pow2_tab_t   tab;
		logic [63:0] root [4];
		logic [63:0] v;
		logic [63:0] m;
		v = 64'd2 << 30;
		for (int k = 0; k < 4; k++) begin
			v       = isqrt64(v << 30);
			root[k] = v;
		end
		for (int i = 0; i < 16; i++) begin
			m = 64'd1 << 30;
			for (int k = 0; k < 4; k++) begin
				if (((i >> (3 - k)) & 1) != 0) m = (m * root[k] + (64'd1 << 29)) >> 30;
			end
			tab[i] = m[31:0];
		end
		tab[16] = 32'd2 << 30;
		return tab;
	endfunction

	localparam pow2_tab_t POW2_TAB = build_pow2();

	// Add with saturation at 2^48-1
	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? '1 : s[47:0];
	endfunction

endpackage

// ===== sv/bsh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bsh_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/bias_scaled_soft_histogram.sv =====
// Soft-binned intensity histogram with bias scaling, one shared multiplier.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | tuser kind, tdata intensity/log_bias/bin_index
//  m_*     | out | m_tvalid/m_tready  | tdata bin_density/total_count
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A sample steps through exponent, mantissa and product and updates two adjacent bins,
// ending early when the scaled intensity is zero or falls outside the bins; a read scales
// the bin and divides bit-serially unless the total is zero or the quotient saturates.
// The 32x32 multiplier and the one read/one write bin RAM are shared by all steps.
// After reset, and on a clear, the block sweeps every RAM bin to zero before s_tready.
// A finished read waits in the output register; the next item is taken meanwhile,
// and a second read holds its result until the register frees up.
module bias_scaled_soft_histogram
	import bsh_pkg::*;
#(
	parameter int MAX_BINS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // intensity[15:0], log_bias[31:16], bin_index[41:32], 0
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // bin_density[31:0], total_count[63:32]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

`include "bias_scaled_soft_histogram_defines.svh"

	localparam int AW = $clog2(MAX_BINS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);
	localparam logic [14:0] MAXB = 15'(MAX_BINS);

	st_t state_q, state_d;

	logic [31:0]   bin_scale_q;
	logic [10:0]   num_bins_q;
	logic [AW-1:0] clr_q;
	logic [63:0]   prod_q;
	logic [31:0]   mul_a, mul_b;
	logic [32:0]   u_q;
	logic [47:0]   y0_q;
	logic [31:0]   m_q;
	logic [63:0]   pl_q;
	logic [79:0]   p_q;
	logic [AW-1:0] iy_q;
	logic [15:0]   dy_q;
	logic [47:0]   total_q;
	logic [15:0]   hhi_q;
	logic [47:0]   rem_q;
	logic [31:0]   lo_q;
	logic [31:0]   q_q;
	logic [4:0]    cnt_q;
	logic [15:0]   inten_q;
	logic [15:0]   lbias_q;
	logic [9:0]    idx_q;
	logic          is_read_q;
	logic          out_valid_q;
	logic [63:0]   out_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [47:0]   ram_wdata, ram_rdata;

	logic          s_xfer;
	logic [3:0]    seg;
	logic [4:0]    e_exp;
	logic [5:0]    sh;
	logic [79:0]   y_full;
	logic [14:0]   nb_eff;
	logic [79:0]   y_bound;
	logic          y_in;
	logic          idx_ok;
	logic [47:0]   h_val;
	logic [48:0]   rem2;
	logic          q_bit;
	logic [32:0]   rt_sum;
	logic [31:0]   rt_val;
	logic          out_free;

	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign out_free  = !out_valid_q || m_tready;

	// Exponent split of u = log_bias/ln2 + 16 in Q28
	assign seg   = u_q[27:24];
	assign e_exp = u_q[32:28];
	assign sh    = 6'd46 - {1'b0, e_exp};

	// Bin position and range check
	always_comb begin
		nb_eff = {4'b0, num_bins_q};
		if (nb_eff > MAXB) nb_eff = MAXB;
		if (nb_eff < 15'd2) nb_eff = 15'd2;
	end
	assign y_full  = p_q >> sh;
	assign y_bound = {49'b0, 15'(nb_eff - 15'd1), 16'b0};
	assign y_in    = y_full < y_bound;

	assign idx_ok = {5'b0, idx_q} < MAXB;
	assign h_val  = idx_ok ? ram_rdata : '0;

	// Restoring divider step
	assign rem2  = {rem_q, lo_q[31]};
	assign q_bit = rem2 >= {1'b0, total_q};

	// Total rounded half to even, saturated
	always_comb begin
		logic inc;
		inc = (total_q[15:0] > 16'h8000) || (total_q[15:0] == 16'h8000 && total_q[16]);
		rt_sum = {1'b0, total_q[47:16]} + {32'b0, inc};
		rt_val = rt_sum[32] ? '1 : rt_sum[31:0];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:  if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			ST_IDLE: begin
				if (s_xfer) begin
					case (s_tuser)
						KIND_ADD:   state_d = ST_U;
						KIND_READ:  state_d = ST_RA;
						KIND_CLEAR: state_d = ST_CLR;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_U:    state_d = ST_Y0;
			ST_Y0:   state_d = ST_DM;
			ST_DM:   state_d = (prod_q[47:0] == '0) ? ST_IDLE : ST_M;
			ST_M:    state_d = ST_PL;
			ST_PL:   state_d = ST_PH;
			ST_PH:   state_d = ST_PS;
			ST_PS:   state_d = is_read_q ? ST_DC : ST_SH;
			ST_SH:   state_d = y_in ? ST_W0 : ST_IDLE;
			ST_W0:   state_d = ST_W1;
			ST_W1:   state_d = ST_IDLE;
			ST_RA:   state_d = ST_H;
			ST_H:    state_d = ST_HH;
			ST_HH:   state_d = ST_PS;
			ST_DC: begin
				if (total_q == '0 || p_q[79:32] >= total_q) state_d = ST_OUT;
				else state_d = ST_DIV;
			end
			ST_DIV:  if (cnt_q == 5'd31) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, RAM port, multiplier operands
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = iy_q;
		ram_wdata = '0;
		ram_raddr = iy_q;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: s_tready = 1'b1;
			ST_U: begin
				mul_a = {16'b0, lbias_q ^ 16'h8000};
				mul_b = LOG2E_Q16;
			end
			ST_Y0: begin
				mul_a = {16'b0, inten_q};
				mul_b = bin_scale_q;
			end
			ST_DM: begin
				mul_a = POW2_TAB[5'(seg) + 5'd1] - POW2_TAB[seg];
				mul_b = {8'b0, u_q[23:0]};
			end
			ST_PL: begin
				mul_a = y0_q[31:0];
				mul_b = m_q;
			end
			ST_PH: begin
				mul_a = {16'b0, y0_q[47:32]};
				mul_b = m_q;
			end
			ST_SH: ram_raddr = y_full[16 +: AW];
			ST_W0: begin
				ram_we    = 1'b1;
				ram_wdata = sat_add48(ram_rdata, ONE_Q16 - {32'b0, dy_q});
				ram_raddr = iy_q + AW'(1);
			end
			ST_W1: begin
				ram_we    = 1'b1;
				ram_waddr = iy_q + AW'(1);
				ram_wdata = sat_add48(ram_rdata, {32'b0, dy_q});
			end
			ST_RA: ram_raddr = AW'(idx_q);
			ST_H: begin
				mul_a = h_val[31:0];
				mul_b = bin_scale_q;
			end
			ST_HH: begin
				mul_a = {16'b0, hhi_q};
				mul_b = bin_scale_q;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			bin_scale_q <= BIN_SCALE_RST;
			num_bins_q  <= NUM_BINS_RST;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BIN_SCALE) bin_scale_q <= cfg_data;
				else if (cfg_index == REG_NUM_BINS) num_bins_q <= cfg_data[10:0];
			end
			if (state_q == ST_CLR) begin
				clr_q   <= clr_q + AW'(1);
				total_q <= '0;
			end else begin
				clr_q <= '0;
			end
			if (state_q == ST_W1) total_q <= sat_add48(total_q, ONE_Q16);
			if (state_q == ST_DIV) cnt_q <= cnt_q + 5'd1;
			else cnt_q <= '0;
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
		if (s_xfer) begin
			inten_q   <= s_tdata[15:0];
			lbias_q   <= s_tdata[31:16];
			idx_q     <= s_tdata[41:32];
			is_read_q <= (s_tuser == KIND_READ);
		end
		case (state_q)
			ST_Y0: u_q  <= prod_q[32:0] + U_OFS;
			ST_DM: y0_q <= prod_q[47:0];
			ST_M:  m_q  <= POW2_TAB[seg] + prod_q[55:24];
			ST_PH: pl_q <= prod_q;
			ST_HH: pl_q <= prod_q;
			ST_PS: p_q  <= {prod_q[47:0], 32'b0} + {16'b0, pl_q};
			ST_SH: begin
				iy_q <= y_full[16 +: AW];
				dy_q <= y_full[15:0];
			end
			ST_H:  hhi_q <= h_val[47:32];
			ST_DC: begin
				rem_q <= p_q[79:32];
				lo_q  <= p_q[31:0];
				if (total_q == '0) q_q <= '0;
				else q_q <= '1;
			end
			ST_DIV: begin
				rem_q <= q_bit ? 48'(rem2 - {1'b0, total_q}) : rem2[47:0];
				lo_q  <= {lo_q[30:0], 1'b0};
				q_q   <= {q_q[30:0], q_bit};
			end
			ST_OUT: if (out_free) out_q <= {rt_val, q_q};
			default: ;
		endcase
	end

	bsh_ram #(
		.WIDTH(48),
		.DEPTH(MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`BSH_ASSERT_IMP(a_we_states, ram_we, (state_q == ST_CLR || state_q == ST_W0 || state_q == ST_W1), "bin write outside clear or update")
	`BSH_ASSERT_IMP(a_div_den, state_q == ST_DIV, total_q != '0, "divider running on zero total")
	`BSH_ASSERT_NXT(a_read_start, s_xfer && s_tuser == KIND_READ, state_q == ST_RA, "read item did not start lookup")
	`BSH_ASSERT_NXT(a_pair_adj, state_q == ST_W0, ram_waddr == $past(ram_waddr) + AW'(1), "bin pair not adjacent")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the bias-scaled soft histogram.
`timescale 1ns / 1ps

module tb_top;
	import bsh_pkg::*;

	localparam int HIST_BINS   = 1024;
	localparam int CYCLE_LIMIT = 3000000;
	// a clear sweeps every bin and gives no result, so wait that long before config
	localparam int QUIET_CYCLES = HIST_BINS + 200;
	// kind code with no operation behind it
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] density;
		logic [31:0] total;
	} read_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // intensity[15:0], log_bias[31:16], bin_index[41:32], 0
	logic [1:0]  s_tuser;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // bin_density[31:0], total_count[63:32]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	// Mirror of the block state
	logic [47:0]  hist_bins [HIST_BINS];
	logic [47:0]  hist_total;
	logic [31:0]  cur_scale;
	logic [10:0]  cur_bins;
	logic [31:0]  exp2_tab [17];
	read_result_t pending_reads [$];

	int errors;
	int cycles;
	int n_samples, n_hits, n_reads, n_clears, n_writes;
	int burst_left;
	int rdy_mode, rdy_left;

	bias_scaled_soft_histogram u_top (.*);

	// Clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run time guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver stall pattern: free running, random, or long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rdy_mode <= 0;
			rdy_left <= 0;
		end else begin
			if (rdy_left == 0) begin
				rdy_mode <= $urandom_range(0, 2);
				rdy_left <= $urandom_range(50, 400);
			end else begin
				rdy_left <= rdy_left - 1;
			end
			case (rdy_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			read_result_t want;
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata[31:0] !== want.density) begin
					$display("%0t: bin_density expected %h actual %h",
						$time, want.density, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== want.total) begin
					$display("%0t: total_count expected %h actual %h",
						$time, want.total, m_tdata[63:32]);
					errors++;
				end
			end
		end
	end

	// floor(sqrt(v)) by binary search
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0]  lo, hi, mid;
		logic [127:0] sq;
		lo = 0;
		hi = 64'd1 << 32;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			sq  = 128'(mid) * 128'(mid);
			if (sq <= 128'(v)) lo = mid;
			else hi = mid;
		end
		return lo;
	endfunction

	// 2^(i/16) in Q30, built from successive square roots of two
	task automatic build_exp2_tab();
		logic [63:0] r [4];
		logic [63:0] acc;
		acc = 64'd2 << 30;
		for (int k = 0; k < 4; k++) begin
			acc  = root_floor(acc << 30);
			r[k] = acc;
		end
		for (int i = 0; i < 16; i++) begin
			acc = 64'd1 << 30;
			for (int k = 0; k < 4; k++)
				if (i[3 - k]) acc = (acc * r[k] + (64'd1 << 29)) >> 30;
			exp2_tab[i] = acc[31:0];
		end
		exp2_tab[16] = 32'd2 << 30;
	endtask

	function automatic logic [47:0] add_clip48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
	endfunction

	// Accumulate one voxel into the mirrored histogram
	task automatic accumulate_voxel(input logic [15:0] inten, input logic [15:0] lb);
		logic [47:0]  y0;
		longint       t;
		logic [63:0]  u, frac, w, mant;
		logic [127:0] prod, yv;
		logic [10:0]  nb;
		int           e, seg, sh;
		logic [63:0]  iy, dy;
		y0 = 48'(inten) * 48'(cur_scale);
		if (y0 == 0) return;
		nb = cur_bins;
		if (nb < 2) nb = 2;
		if (nb > HIST_BINS) nb = HIST_BINS;
		t    = longint'($signed(lb)) * 94548;
		u    = t + (64'sd16 << 28);
		e    = int'(u >> 28);
		frac = u & ((64'd1 << 28) - 1);
		seg  = int'(frac >> 24);
		w    = frac & 64'hFF_FFFF;
		mant = exp2_tab[seg] + (((64'(exp2_tab[seg + 1]) - exp2_tab[seg]) * w) >> 24);
		sh   = 46 - e;
		prod = 128'(y0) * 128'(mant);
		yv   = prod >> sh;
		if (yv[127:64] != 0) return;
		if (yv[63:0] >= (64'(nb - 1) << 16)) return;
		iy = yv[63:0] >> 16;
		dy = yv[63:0] & 64'hFFFF;
		hist_bins[iy]     = add_clip48(hist_bins[iy], 48'(65536 - dy));
		hist_bins[iy + 1] = add_clip48(hist_bins[iy + 1], 48'(dy));
		hist_total        = add_clip48(hist_total, 48'd65536);
		n_hits++;
	endtask

	function automatic read_result_t read_density(input logic [9:0] idx);
		read_result_t r;
		logic [127:0] num;
		logic [47:0]  q;
		num = 128'(hist_bins[idx]) * 128'(cur_scale);
		if (hist_total == 0) r.density = 0;
		else if (num >= (128'(hist_total) << 32)) r.density = 32'hFFFF_FFFF;
		else r.density = 32'(num / 128'(hist_total));
		q = hist_total >> 16;
		if (hist_total[15:0] > 16'h8000 || (hist_total[15:0] == 16'h8000 && q[0])) q++;
		r.total = (q > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		return r;
	endfunction

	// Send one item with bursty valid
	task automatic send_item(input logic [1:0] kind, input logic [15:0] inten,
			input logic [15:0] lb, input logic [9:0] idx);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'b0, idx, lb, inten};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (kind)
			KIND_ADD: begin
				n_samples++;
				accumulate_voxel(inten, lb);
			end
			KIND_READ: begin
				n_reads++;
				pending_reads.push_back(read_density(idx));
			end
			KIND_CLEAR: begin
				n_clears++;
				foreach (hist_bins[i]) hist_bins[i] = 0;
				hist_total = 0;
			end
			default: ;
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Drain results and let a pending clear finish
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_writes++;
		if (idx == REG_BIN_SCALE) cur_scale = val;
		else if (idx == REG_NUM_BINS) cur_bins = val[10:0];
		@(posedge clk);
	endtask

	// One random item, mostly voxels aimed inside the bin range
	task automatic send_random_item();
		int          pick, nb, target;
		logic [63:0] iv;
		logic [15:0] lb;
		pick = $urandom_range(0, 99);
		nb = (cur_bins < 2) ? 2 : (cur_bins > HIST_BINS) ? HIST_BINS : cur_bins;
		if (pick < 55) begin
			target = $urandom_range(0, nb - 1);
			lb     = 16'($signed($urandom_range(0, 3000)) - 1500);
			iv     = ((64'(target) << 16) + $urandom_range(0, 65535)) / (cur_scale | 1);
			if (iv > 65535) iv = $urandom_range(0, 65535);
			send_item(KIND_ADD, iv[15:0], lb, $urandom);
		end else if (pick < 70) begin
			send_item(KIND_ADD, $urandom, $urandom, $urandom);
		end else if (pick < 96) begin
			if ($urandom_range(0, 3) == 0) send_item(KIND_READ, $urandom, $urandom, $urandom);
			else send_item(KIND_READ, $urandom, $urandom, $urandom_range(0, nb - 1));
		end else if (pick < 99) begin
			send_item(KIND_UNUSED, $urandom, $urandom, $urandom);
		end else begin
			send_item(KIND_CLEAR, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic test_empty_after_reset();
		send_item(KIND_READ, 16'h0, 16'h0, 10'd0);
		send_item(KIND_READ, 16'h0, 16'h0, 10'd1023);
	endtask

	task automatic test_field_extremes();
		send_item(KIND_ADD, 16'd0, 16'd0, 10'd0);          // zero intensity
		send_item(KIND_ADD, 16'd1, 16'd0, 10'd0);
		send_item(KIND_ADD, 16'd100, 16'h0800, 10'd0);
		send_item(KIND_ADD, 16'd500, 16'hF000, 10'd0);
		send_item(KIND_ADD, 16'hFFFF, 16'h0000, 10'd0);    // beyond the top bin
		send_item(KIND_ADD, 16'hFFFF, 16'h8000, 10'h3FF);  // most negative bias
		send_item(KIND_ADD, 16'd1, 16'h7FFF, 10'd0);       // most positive bias
		send_item(KIND_ADD, 16'd1023, 16'h0000, 10'd0);    // exactly on the last edge
		send_item(KIND_ADD, 16'd1021, 16'h0000, 10'd0);
		send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF);
		send_item(KIND_READ, 16'h0, 16'h0, 10'd100);
		send_item(KIND_READ, 16'hFFFF, 16'hFFFF, 10'd1021);
		send_item(KIND_READ, 16'h0, 16'h0, 10'd1022);
		send_item(KIND_READ, 16'h0, 16'h0, 10'd1023);
		send_item(KIND_CLEAR, 16'h0, 16'h0, 10'd0);
		send_item(KIND_READ, 16'h0, 16'h0, 10'd100);       // cleared store
		send_item(KIND_ADD, 16'd3, 16'h0000, 10'd0);
		send_item(KIND_READ, 16'h0, 16'h0, 10'd3);
	endtask

	// Config phases, each followed by random traffic
	task automatic test_config_sweep();
		logic [31:0] scales [8];
		logic [31:0] bin_cnt [8];
		scales  = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd6553, 32'd655360,
			32'd30000, 32'd65536};
		bin_cnt = '{32'd0, 32'd1, 32'd2, 32'h7FF, 32'd1024, 32'd17, 32'd300, 32'd1024};
		for (int p = 0; p < 8; p++) begin
			wait_quiet();
			write_reg(REG_BIN_SCALE, scales[p]);
			write_reg(REG_NUM_BINS, bin_cnt[p]);
			if (p == 2) write_reg(8'd2, 32'h1234_5678);   // unknown register
			if (p == 4) write_reg(8'hFF, 32'hFFFF_FFFF);
			repeat (210) send_random_item();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		errors = 0; cycles = 0; burst_left = 0;
		n_samples = 0; n_hits = 0; n_reads = 0; n_clears = 0; n_writes = 0;
		build_exp2_tab();
		foreach (hist_bins[i]) hist_bins[i] = 0;
		hist_total = 0;
		cur_scale  = BIN_SCALE_RST;
		cur_bins   = NUM_BINS_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_after_reset();
		test_field_extremes();
		test_config_sweep();

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d voxels (%0d binned), %0d reads, %0d clears, %0d register writes",
			n_samples, n_hits, n_reads, n_clears, n_writes);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== bias_scaled_soft_histogram.f =====
+incdir+sv
sv/bsh_pkg.sv
sv/bsh_ram.sv
sv/bias_scaled_soft_histogram.sv
dv/tb_top.sv
